@@ hdl/bdg_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and constants of the button debounce and gesture detector.
package bdg_pkg;

  // Raw sample history length and register widths
  localparam int HistoryBits = 16;
  localparam int MaskBits    = 16;
  localparam int CmpBits     = (HistoryBits > MaskBits) ? HistoryBits : MaskBits;
  localparam int CntBits     = 32;
  localparam int MsBits      = 16;
  localparam int CfgIdxBits  = 3;

  // Request kinds carried on the input tuser
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_READ = 1'b1
  } op_t;

  // Reported gesture codes
  typedef enum logic [2:0] {
    GEST_NONE       = 3'd0,
    GEST_CLICK      = 3'd1,
    GEST_DOUBLE     = 3'd2,
    GEST_PRESS      = 3'd3,
    GEST_HELD       = 3'd4,
    GEST_CLICK_HELD = 3'd5
  } gesture_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxBits-1:0] {
    CFG_DEBOUNCE  = 3'd0,
    CFG_PRESS     = 3'd1,
    CFG_HOLD      = 3'd2,
    CFG_DOUBLE    = 3'd3,
    CFG_DOUBLE_EN = 3'd4,
    CFG_RISE_MASK = 3'd5,
    CFG_FALL_MASK = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic [MsBits-1:0]   debounce_ms;
    logic [MsBits-1:0]   press_ms;
    logic [MsBits-1:0]   hold_ms;
    logic [MsBits-1:0]   double_ms;
    logic                double_en;
    logic [MaskBits-1:0] rise_mask;
    logic [MaskBits-1:0] fall_mask;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    debounce_ms: 16'd20,
    press_ms:    16'd500,
    hold_ms:     16'd1500,
    double_ms:   16'd300,
    double_en:   1'b1,
    rise_mask:   16'h000F,
    fall_mask:   16'hFFF0
  };

  // One input request
  typedef struct packed {
    op_t               op;
    logic              pin;
    logic [MsBits-1:0] elapsed;
  } item_t;

  // Debounced level and time since last change, after the current request
  typedef struct packed {
    logic               level_down;
    logic [CntBits-1:0] ms_since_change;
  } deb_status_t;

endpackage

@@ hdl/bdg_debounce.sv @@
`timescale 1ns / 1ps
// Sample history, saturating change timer and debounced level.
module bdg_debounce (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  bdg_pkg::item_t       item,
  input  bdg_pkg::cfg_t        cfg,
  output bdg_pkg::deb_status_t status
);

  localparam int SumBits = bdg_pkg::CntBits + 1;

  logic [bdg_pkg::HistoryBits-1:0] history;
  logic [bdg_pkg::HistoryBits-1:0] history_next;
  logic                            level_down;
  logic                            level_next;
  logic [bdg_pkg::CntBits-1:0]     count;
  logic [bdg_pkg::CntBits-1:0]     count_next;
  logic [SumBits-1:0]              sum;
  logic [bdg_pkg::CmpBits-1:0]     hist_w;
  logic [bdg_pkg::CmpBits-1:0]     rise_w;
  logic [bdg_pkg::CmpBits-1:0]     fall_w;
  logic                            is_tick;

  // Shift the sample in, advance the timer, test the masks
  always_comb begin
    is_tick      = (item.op == bdg_pkg::OP_TICK);
    history_next = is_tick ? {history[bdg_pkg::HistoryBits-2:0], item.pin} : history;
    sum          = {1'b0, count} + SumBits'(item.elapsed);
    hist_w       = bdg_pkg::CmpBits'(history_next);
    rise_w       = bdg_pkg::CmpBits'(cfg.rise_mask);
    fall_w       = bdg_pkg::CmpBits'(cfg.fall_mask);
    count_next   = count;
    level_next   = level_down;
    if (is_tick) begin
      count_next = sum[bdg_pkg::CntBits] ? '1 : sum[bdg_pkg::CntBits-1:0];
      if (count_next >= bdg_pkg::CntBits'(cfg.debounce_ms)) begin
        if (!level_down) begin
          if ((hist_w & rise_w) == rise_w) begin
            level_next = 1'b1;
            count_next = '0;
          end
        end else if ((hist_w | fall_w) == fall_w) begin
          level_next = 1'b0;
          count_next = '0;
        end
      end
    end
    status.level_down      = level_next;
    status.ms_since_change = count_next;
  end

  // Commit on each processed request
  always_ff @(posedge clk) begin
    if (rst) begin
      history    <= '0;
      level_down <= 1'b0;
      count      <= '1;
    end else if (en) begin
      history    <= history_next;
      level_down <= level_next;
      count      <= count_next;
    end
  end

endmodule

@@ hdl/bdg_tracker.sv @@
`timescale 1ns / 1ps
// Gesture state machine with latched report and read acknowledge.
module bdg_tracker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  bdg_pkg::item_t       item,
  input  bdg_pkg::deb_status_t status,
  input  bdg_pkg::cfg_t        cfg,
  output bdg_pkg::gesture_t    gesture
);

  typedef enum logic [7:0] {
    ST_OPEN       = 8'b0000_0001,
    ST_CLOSED     = 8'b0000_0010,
    ST_CLICKED    = 8'b0000_0100,
    ST_DOUBLE     = 8'b0000_1000,
    ST_PRESSED    = 8'b0001_0000,
    ST_HELD       = 8'b0010_0000,
    ST_CLICK_HELD = 8'b0100_0000,
    ST_RELEASED   = 8'b1000_0000
  } track_state_t;

  track_state_t               state;
  track_state_t               state_next;
  bdg_pkg::gesture_t          reported;
  bdg_pkg::gesture_t          reported_next;
  logic                       acked;
  logic                       acked_next;
  logic [bdg_pkg::MsBits-1:0] hold_wait;
  logic                       down;
  logic                       t_press;
  logic                       t_double;
  logic                       t_hold;

  // Classify the gesture from the debounced level and elapsed time
  always_comb begin
    hold_wait     = (cfg.hold_ms > cfg.press_ms) ? cfg.hold_ms - cfg.press_ms : '0;
    down          = status.level_down;
    t_press       = status.ms_since_change >= bdg_pkg::CntBits'(cfg.press_ms);
    t_double      = status.ms_since_change >= bdg_pkg::CntBits'(cfg.double_ms);
    t_hold        = status.ms_since_change >= bdg_pkg::CntBits'(hold_wait);
    state_next    = state;
    reported_next = reported;
    acked_next    = acked;
    if (item.op == bdg_pkg::OP_READ) begin
      // Acknowledge only once the button is back up
      if (state == ST_RELEASED) begin
        acked_next = 1'b1;
      end
    end else begin
      unique case (state)
        ST_OPEN: begin
          reported_next = bdg_pkg::GEST_NONE;
          if (down) begin
            state_next = ST_CLOSED;
          end
        end
        ST_CLOSED: begin
          if (!down) begin
            if (!cfg.double_en) begin
              reported_next = bdg_pkg::GEST_CLICK;
              state_next    = ST_RELEASED;
              acked_next    = 1'b0;
            end else begin
              state_next = ST_CLICKED;
            end
          end else if (t_press) begin
            state_next = ST_PRESSED;
          end
        end
        ST_CLICKED: begin
          if (down) begin
            if (!t_double) begin
              state_next = ST_DOUBLE;
            end
          end else if (t_double) begin
            reported_next = bdg_pkg::GEST_CLICK;
            state_next    = ST_RELEASED;
            acked_next    = 1'b0;
          end
        end
        ST_DOUBLE: begin
          if (t_double) begin
            acked_next = 1'b0;
            if (down) begin
              reported_next = bdg_pkg::GEST_CLICK_HELD;
              state_next    = ST_CLICK_HELD;
            end else begin
              reported_next = bdg_pkg::GEST_DOUBLE;
              state_next    = ST_RELEASED;
            end
          end
        end
        ST_PRESSED: begin
          if (!down) begin
            reported_next = bdg_pkg::GEST_PRESS;
            state_next    = ST_RELEASED;
            acked_next    = 1'b0;
          end else if (t_hold) begin
            reported_next = bdg_pkg::GEST_HELD;
            state_next    = ST_HELD;
            acked_next    = 1'b0;
          end
        end
        ST_HELD, ST_CLICK_HELD: begin
          if (!down) begin
            state_next = ST_RELEASED;
          end
        end
        ST_RELEASED: begin
          if (acked) begin
            state_next    = ST_OPEN;
            reported_next = bdg_pkg::GEST_NONE;
          end
        end
        default: begin
          state_next    = ST_OPEN;
          reported_next = bdg_pkg::GEST_NONE;
        end
      endcase
    end
    gesture = reported_next;
  end

  // Commit on each processed request
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_OPEN;
      reported <= bdg_pkg::GEST_NONE;
      acked    <= 1'b0;
    end else if (en) begin
      state    <= state_next;
      reported <= reported_next;
      acked    <= acked_next;
    end
  end

endmodule

@@ hdl/button_debounce_gesture_fsm.sv @@
`timescale 1ns / 1ps
// Top level: input register, debounce and gesture logic, result register, config.
// Button debouncer and gesture detector. Each request is a service tick (raw pin
// sample in s_tdata[0], elapsed milliseconds in s_tdata[16:1], s_tuser low) or a
// read (s_tuser high), and each request yields exactly one result: the latched
// gesture in m_tdata[2:0] (0 none, 1 click, 2 double click, 3 press, 4 held,
// 5 click and held) and the debounced level in m_tdata[3]. One request is taken
// every clock cycle while the result register drains; a request waits in the
// input register until the result slot frees. The debounce timer and gesture
// state update combinationally between the input and result registers.
// A latched gesture is cleared by the first tick after a read that arrives once
// the button is released. Configuration writes are taken at any time but are
// meant to be made while no request is in flight.
module button_debounce_gesture_fsm (
  input  logic                             clk,
  input  logic                             rst,
  // Request stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [23:0]                      s_tdata,   // pin_level, elapsed_ms[15:0], zero pad
  input  logic                             s_tuser,   // operation
  // Result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [7:0]                       m_tdata,   // gesture[2:0], debounced_down, zero pad
  // Configuration writes
  input  logic                             cfg_wr_en,
  input  logic [bdg_pkg::CfgIdxBits-1:0]   cfg_index,
  input  logic [bdg_pkg::MsBits-1:0]       cfg_data
);

  bdg_pkg::cfg_t        cfg;
  logic                 in_valid;
  bdg_pkg::item_t       in_item;
  logic                 advance;
  logic                 accept;
  bdg_pkg::deb_status_t status;
  bdg_pkg::gesture_t    gesture_next;
  logic                 out_valid;
  bdg_pkg::gesture_t    out_gesture;
  logic                 out_level;

  // Write configuration registers; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= bdg_pkg::CfgReset;
    end else if (cfg_wr_en) begin
      unique case (bdg_pkg::cfg_index_t'(cfg_index))
        bdg_pkg::CFG_DEBOUNCE:  cfg.debounce_ms <= cfg_data;
        bdg_pkg::CFG_PRESS:     cfg.press_ms    <= cfg_data;
        bdg_pkg::CFG_HOLD:      cfg.hold_ms     <= cfg_data;
        bdg_pkg::CFG_DOUBLE:    cfg.double_ms   <= cfg_data;
        bdg_pkg::CFG_DOUBLE_EN: cfg.double_en   <= cfg_data[0];
        bdg_pkg::CFG_RISE_MASK: cfg.rise_mask   <= cfg_data;
        bdg_pkg::CFG_FALL_MASK: cfg.fall_mask   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: move the held request forward whenever the result slot frees
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign accept   = s_tvalid && s_tready;

  // Capture the request
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item.op      <= bdg_pkg::op_t'(s_tuser);
      in_item.pin     <= s_tdata[0];
      in_item.elapsed <= s_tdata[bdg_pkg::MsBits:1];
    end
  end

  bdg_debounce u_debounce (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .item   (in_item),
    .cfg    (cfg),
    .status (status)
  );

  bdg_tracker u_tracker (
    .clk     (clk),
    .rst     (rst),
    .en      (advance),
    .item    (in_item),
    .status  (status),
    .cfg     (cfg),
    .gesture (gesture_next)
  );

  // Hold the result until the downstream side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      out_gesture <= bdg_pkg::GEST_NONE;
      out_level   <= 1'b0;
    end else if (advance) begin
      out_valid   <= 1'b1;
      out_gesture <= gesture_next;
      out_level   <= status.level_down;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_level, out_gesture};

  // A read never changes the latched gesture
  assert property (@(posedge clk) disable iff (rst)
    advance && (in_item.op == bdg_pkg::OP_READ) |=> out_gesture == $past(out_gesture))
    else $error("gesture changed on a read request");

  // A read never changes the debounced level
  assert property (@(posedge clk) disable iff (rst)
    advance && (in_item.op == bdg_pkg::OP_READ) |=> out_level == $past(out_level))
    else $error("debounced level changed on a read request");

  // An empty result slot always lets a new request in
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> s_tready)
    else $error("input stalled with an empty result register");

  // A held request is not dropped while stalled
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid)
    else $error("held request lost while stalled");

endmodule
